// ----- hw/rtl/matrix_keypad_scan_password_defines.svh -----
// Assertion helpers for the keypad scanner RTL, used by mkp_scan_core.
`ifndef MATRIX_KEYPAD_SCAN_PASSWORD_DEFINES_SVH
`define MATRIX_KEYPAD_SCAN_PASSWORD_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MKP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked out of reset.
`define MKP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- hw/rtl/mkp_pkg.sv -----
`default_nettype none
package mkp_pkg;

  localparam logic [3:0]  NO_KEY      = 4'b1111;
  localparam logic [3:0]  COL3_LOW    = 4'b1110;
  localparam logic [3:0]  COL2_LOW    = 4'b1101;
  localparam logic [3:0]  COL1_LOW    = 4'b1011;
  localparam logic [15:0] DEBOUNCE_RST = 16'd20;
  localparam logic [7:0]  CODE_RST    = 8'h30;   // '0'

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_CODE0    = 2'd1,
    CFG_CODE1    = 2'd2,
    CFG_CODE2    = 2'd3
  } mkp_cfg_idx_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [7:0]  code_char_first;
    logic [7:0]  code_char_second;
    logic [7:0]  code_char_third;
  } mkp_cfg_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_valid;
    logic [7:0] key_code;
    logic [1:0] key_row;
    logic [1:0] key_col;
    logic       code_done;
    logic       code_match;
  } mkp_res_t;

  // Rows 0..3: "123A" "456B" "789C" "*0=D"
  function automatic logic [7:0] key_map(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] ch;
    unique case ({row, col})
      4'h0: ch = "1";
      4'h1: ch = "2";
      4'h2: ch = "3";
      4'h3: ch = "A";
      4'h4: ch = "4";
      4'h5: ch = "5";
      4'h6: ch = "6";
      4'h7: ch = "B";
      4'h8: ch = "7";
      4'h9: ch = "8";
      4'hA: ch = "9";
      4'hB: ch = "C";
      4'hC: ch = "*";
      4'hD: ch = "0";
      4'hE: ch = "=";
      default: ch = "D";
    endcase
    return ch;
  endfunction

  // Active-low row drive: bit (3 - row) low.
  function automatic logic [3:0] drive_for_row(input logic [1:0] row);
    logic [3:0] d;
    d = 4'b1111;
    d[2'd3 - row] = 1'b0;
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/matrix_keypad_scan_password.sv -----
// 4x4 active-low keypad scanner with a three-key code check.
// Input stream: one request per sampling tick, in_tdata[3:0] = column levels
// read under the row drive of the previous result (15 = no key).
// Output stream: one result per request carrying the next row drive and, when
// a key was decoded, its ASCII code, row and column; code_done/code_match
// flag the third key of an entry and whether the three keys equal the code.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write debounce period (0) and
// the three code characters (1..3); write only while the stream is idle.
// Each result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the receiver takes results; the whole step
// is combinational logic between the scan state registers and the output register.
// If the receiver stalls, the held result waits in the output register and
// in_tready drops until it is taken; nothing is lost or repeated.
// Reset (rst_n low, synchronous): scanner returns to waiting for release,
// counters clear, registers reload debounce 20 and code "000", output empties.
`default_nettype none
module matrix_keypad_scan_password
  import mkp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [3:0] col_sense
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [3:0] row_drive, [4] key_valid, [12:5] key_code,
                                       // [14:13] key_row, [16:15] key_col,
                                       // [17] code_done, [18] code_match
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  mkp_cfg_t cfg_r;
  mkp_res_t res;
  mkp_res_t res_r;
  logic     out_valid_r;
  logic     accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RST;
      cfg_r.code_char_first  <= CODE_RST;
      cfg_r.code_char_second <= CODE_RST;
      cfg_r.code_char_third  <= CODE_RST;
    end else if (cfg_wr_en) begin
      unique case (mkp_cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE: cfg_r.debounce_ticks   <= cfg_wdata;
        CFG_CODE0:    cfg_r.code_char_first  <= cfg_wdata[7:0];
        CFG_CODE1:    cfg_r.code_char_second <= cfg_wdata[7:0];
        CFG_CODE2:    cfg_r.code_char_third  <= cfg_wdata[7:0];
        default:      ;
      endcase
    end
  end

  mkp_scan_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (accept),
    .col_sense (in_tdata[3:0]),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.code_match, res_r.code_done, res_r.key_col,
                       res_r.key_row, res_r.key_code, res_r.key_valid, res_r.row_drive};

endmodule
`default_nettype wire

// ----- hw/rtl/mkp_code_chk.sv -----
`default_nettype none
module mkp_code_chk
  import mkp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       key_en,
  input  wire logic [7:0] key_code,
  input  wire mkp_cfg_t   cfg,
  output logic            code_done,
  output logic            code_match
);

  logic [1:0] digit_count_r, digit_count_nxt;
  logic [1:0] slot;
  logic [7:0] entered_r [3];

  assign slot = (digit_count_r == 2'd3) ? 2'd0 : digit_count_r;

  always_comb begin
    code_done  = key_en && (slot == 2'd2);
    code_match = code_done &&
                 (entered_r[0] == cfg.code_char_first) &&
                 (entered_r[1] == cfg.code_char_second) &&
                 (key_code == cfg.code_char_third);
    digit_count_nxt = digit_count_r;
    if (key_en) begin
      digit_count_nxt = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= 2'd0;
    end else begin
      digit_count_r <= digit_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (key_en) begin
      entered_r[slot] <= key_code;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mkp_scan_core.sv -----
`default_nettype none
`include "matrix_keypad_scan_password_defines.svh"
module mkp_scan_core
  import mkp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic [3:0] col_sense,
  input  wire mkp_cfg_t   cfg,
  output mkp_res_t        res
);

  typedef enum logic [3:0] {
    PH_RELEASE = 4'b0001,
    PH_PRESS   = 4'b0010,
    PH_CONFIRM = 4'b0100,
    PH_SCAN    = 4'b1000
  } mkp_phase_t;

  mkp_phase_t  phase_r, phase_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [1:0]  row_r, row_nxt;

  logic [15:0] tick_inc, period, tick_smp;
  logic        due;
  logic        key_hit;
  logic [1:0]  kcol;
  logic [1:0]  row_dec;
  logic [7:0]  code;
  logic        done, match;

  assign tick_inc = tick_r + 16'd1;
  assign period   = (cfg.debounce_ticks == 16'd0) ? 16'd1 : cfg.debounce_ticks;
  assign due      = (tick_inc >= period);
  assign tick_smp = due ? 16'd0 : tick_inc;
  assign row_dec  = row_r - 2'd1;
  // key seen on the row driven last tick
  assign key_hit  = (phase_r == PH_SCAN) && (col_sense != NO_KEY);

  always_comb begin
    priority if (col_sense == COL3_LOW) kcol = 2'd3;
    else if (col_sense == COL2_LOW)     kcol = 2'd2;
    else if (col_sense == COL1_LOW)     kcol = 2'd1;
    else                                kcol = 2'd0;
  end

  assign code = key_map(row_r, kcol);

  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    row_nxt       = row_r;
    res           = '0;
    unique case (phase_r)
      PH_PRESS: begin
        tick_nxt = tick_smp;
        if (due && col_sense != NO_KEY) phase_nxt = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        tick_nxt = tick_smp;
        if (due) begin
          if (col_sense != NO_KEY) begin
            phase_nxt     = PH_SCAN;
            row_nxt       = 2'd3;
            res.row_drive = drive_for_row(2'd3);
          end else begin
            phase_nxt = PH_PRESS;
          end
        end
      end
      PH_SCAN: begin
        if (col_sense != NO_KEY) begin
          phase_nxt    = PH_RELEASE;
          res.key_valid = 1'b1;
          res.key_code  = code;
          res.key_row   = row_r;
          res.key_col   = kcol;
        end else begin
          row_nxt       = row_dec;
          res.row_drive = drive_for_row(row_dec);
        end
      end
      default: begin
        phase_nxt = PH_RELEASE;
        if (col_sense == NO_KEY) begin
          phase_nxt = PH_PRESS;
          tick_nxt  = 16'd0;
        end
      end
    endcase
    res.code_done  = done;
    res.code_match = match;
  end

  mkp_code_chk u_code_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_en     (en && key_hit),
    .key_code   (code),
    .cfg        (cfg),
    .code_done  (done),
    .code_match (match)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RELEASE;
      tick_r  <= 16'd0;
      row_r   <= 2'd0;
    end else if (en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      row_r   <= row_nxt;
    end
  end

  `MKP_ASSERT_IMP(a_key_drops_rows, res.key_valid, res.row_drive == 4'd0)
  `MKP_ASSERT_IMP(a_done_needs_key, res.code_done, res.key_valid)
  `MKP_ASSERT_IMP(a_match_needs_done, res.code_match, res.code_done)
  `MKP_ASSERT_NXT(a_key_to_release, en && key_hit, phase_r == PH_RELEASE)

endmodule
`default_nettype wire

// ----- bench/matrix_keypad_scan_password_test.sv -----
module matrix_keypad_scan_password_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mkp_pkg::*;

  localparam int LIMIT = 400000;
  localparam logic [127:0] KEY_CHARS = "123A456B789C*0=D";
  localparam mkp_res_t IDLE_RES = '0;

  typedef enum logic [2:0] {
    AWAIT_RELEASE,
    AWAIT_PRESS,
    AWAIT_CONFIRM,
    ROW_SCAN
  } scan_state_t;

  typedef struct packed {
    logic [3:0] col;
    logic       typed;
    mkp_res_t   want;
  } tick_row_t;

  // debounce period is 1 for this table, code is "01*"
  localparam tick_row_t DIRECTED [22] = '{
    '{4'h0,     1'b1, IDLE_RES},  // key down out of reset: keep waiting for release
    '{NO_KEY,   1'b1, IDLE_RES},
    '{COL1_LOW, 1'b1, IDLE_RES},
    '{COL1_LOW, 1'b0, IDLE_RES},  // confirmed, scan starts at row 3
    '{COL1_LOW, 1'b1, '{4'h0, 1'b1, "0", 2'd3, 2'd1, 1'b0, 1'b0}},
    '{NO_KEY,   1'b1, IDLE_RES},
    '{4'h7,     1'b1, IDLE_RES},
    '{4'h7,     1'b0, IDLE_RES},
    '{NO_KEY,   1'b0, IDLE_RES},  // walk rows 2, 1, 0
    '{NO_KEY,   1'b0, IDLE_RES},
    '{NO_KEY,   1'b0, IDLE_RES},
    '{4'h7,     1'b1, '{4'h0, 1'b1, "1", 2'd0, 2'd0, 1'b0, 1'b0}},
    '{NO_KEY,   1'b1, IDLE_RES},
    '{4'h0,     1'b1, IDLE_RES},  // every column low, decodes as column 0
    '{4'h0,     1'b0, IDLE_RES},
    '{4'h0,     1'b1, '{4'h0, 1'b1, "*", 2'd3, 2'd0, 1'b1, 1'b1}},
    '{NO_KEY,   1'b1, IDLE_RES},
    '{COL3_LOW, 1'b1, IDLE_RES},
    '{NO_KEY,   1'b1, IDLE_RES},  // bounce: gone at confirm, back to press wait
    '{COL2_LOW, 1'b1, IDLE_RES},
    '{COL2_LOW, 1'b0, IDLE_RES},
    '{COL2_LOW, 1'b1, '{4'h0, 1'b1, "=", 2'd3, 2'd2, 1'b0, 1'b0}}
  };

  localparam logic [15:0] PHASE_DEB [8] = '{
    16'd1, 16'd0, 16'd3, 16'd65535, 16'd2, 16'd5, 16'd20, 16'd1
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [7:0]  in_tdata = '0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [23:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  matrix_keypad_scan_password uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scanner state as predicted, plus the register copies
  scan_state_t scan_state = AWAIT_RELEASE;
  logic [15:0] tick_cnt = '0;
  logic [1:0]  cur_row = '0;
  logic [1:0]  keys_taken = '0;
  logic [7:0]  typed_keys [3];
  logic [15:0] deb_period = DEBOUNCE_RST;
  logic [7:0]  code_want [3] = '{CODE_RST, CODE_RST, CODE_RST};
  logic [3:0]  last_drive = '0;

  mkp_res_t expected_q [$];
  int errors = 0;
  int results_seen = 0;
  int tx_span = 0, rx_span = 0;
  bit tx_eager = 1'b0, rx_eager = 1'b0;

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    return KEY_CHARS[8 * (15 - idx) +: 8];
  endfunction

  function automatic logic [3:0] row_lines(input logic [1:0] row);
    return ~(4'b1000 >> row);
  endfunction

  function automatic bit debounce_due();
    logic [15:0] period;
    period = (deb_period == 16'd0) ? 16'd1 : deb_period;
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= period) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic mkp_res_t scan_tick(input logic [3:0] col);
    mkp_res_t r;
    r = '0;
    case (scan_state)
      AWAIT_PRESS: begin
        if (debounce_due() && col != NO_KEY) scan_state = AWAIT_CONFIRM;
      end
      AWAIT_CONFIRM: begin
        if (debounce_due()) scan_state = (col != NO_KEY) ? ROW_SCAN : AWAIT_PRESS;
        if (scan_state == ROW_SCAN) begin
          cur_row = 2'd3;
          r.row_drive = row_lines(cur_row);
        end
      end
      ROW_SCAN: begin
        if (col != NO_KEY) begin
          case (col)
            COL3_LOW: r.key_col = 2'd3;
            COL2_LOW: r.key_col = 2'd2;
            COL1_LOW: r.key_col = 2'd1;
            default:  r.key_col = 2'd0;
          endcase
          r.key_row = cur_row;
          r.key_code = key_char({cur_row, r.key_col});
          r.key_valid = 1'b1;
          if (keys_taken > 2'd2) keys_taken = '0;
          typed_keys[keys_taken] = r.key_code;
          keys_taken = keys_taken + 2'd1;
          if (keys_taken == 2'd3) begin
            r.code_done = 1'b1;
            r.code_match = (typed_keys[0] == code_want[0]) &&
                           (typed_keys[1] == code_want[1]) &&
                           (typed_keys[2] == code_want[2]);
            keys_taken = '0;
          end
          scan_state = AWAIT_RELEASE;
        end else begin
          cur_row = cur_row - 2'd1;
          r.row_drive = row_lines(cur_row);
        end
      end
      default: begin
        scan_state = AWAIT_RELEASE;
        if (col == NO_KEY) begin
          scan_state = AWAIT_PRESS;
          tick_cnt = '0;
        end
      end
    endcase
    return r;
  endfunction

  // each run is either back-to-back traffic or random gaps, chosen at random
  function automatic int pick_gap(ref int span, ref bit eager);
    if (span == 0) begin
      span = $urandom_range(10, 80);
      eager = ($urandom_range(0, 2) == 0);
    end
    span--;
    return eager ? 0 : int'($urandom_range(0, 19));
  endfunction

  task automatic send_tick(input logic [3:0] col, input logic typed, input mkp_res_t want);
    int gap;
    mkp_res_t pred;
    gap = pick_gap(tx_span, tx_eager);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'h0, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = scan_tick(col);
    last_drive = pred.row_drive;
    expected_q.push_back(typed ? want : pred);
  endtask

  task automatic load_config(input logic [15:0] deb, input logic [7:0] c0,
                             input logic [7:0] c1, input logic [7:0] c2);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= CFG_CODE0;
    cfg_wdata <= {8'h00, c0};
    @(posedge clk);
    cfg_index <= CFG_CODE1;
    cfg_wdata <= {8'h00, c1};
    @(posedge clk);
    cfg_index <= CFG_CODE2;
    cfg_wdata <= {8'h00, c2};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    deb_period = deb;
    code_want[0] = c0;
    code_want[1] = c1;
    code_want[2] = c2;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic check_field(input string field, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
    end
  endtask

  initial begin : stimulus
    logic [3:0]  col, pick, pad_pattern;
    logic [1:0]  pad_row;
    logic [3:0]  palette [2];
    logic [7:0]  code_set [3];
    int          gen_period, pad_left, n_items;
    bit          held;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    load_config(16'd1, "0", "1", "*");
    foreach (DIRECTED[i]) send_tick(DIRECTED[i].col, DIRECTED[i].typed, DIRECTED[i].want);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      palette[0] = 4'($urandom_range(0, 15));
      palette[1] = 4'($urandom_range(0, 15));
      for (int k = 0; k < 3; k++) begin
        // phases 3 and 4 use codes no key can produce
        if (p == 3) code_set[k] = 8'h00;
        else if (p == 4) code_set[k] = 8'hFF;
        else code_set[k] = key_char(palette[$urandom_range(0, 1)]);
      end
      load_config(PHASE_DEB[p], code_set[0], code_set[1], code_set[2]);
      gen_period = (PHASE_DEB[p] == 16'd0) ? 1 :
                   (PHASE_DEB[p] > 16'd40) ? 40 : int'(PHASE_DEB[p]);
      n_items = (PHASE_DEB[p] == 16'hFFFF) ? 150 : 250;
      held = 1'b0;
      pad_left = 0;
      repeat (n_items) begin
        if (pad_left == 0) begin
          held = !held;
          if (held) begin
            pick = ($urandom_range(0, 3) != 0) ? palette[$urandom_range(0, 1)]
                                               : 4'($urandom_range(0, 15));
            pad_row = pick[3:2];
            pad_pattern = ($urandom_range(0, 4) != 0) ? ~(4'b1000 >> pick[1:0])
                                                      : 4'($urandom_range(0, 14));
            // mostly held long enough to confirm and scan, sometimes a short tap
            pad_left = ($urandom_range(0, 6) == 0) ? int'($urandom_range(1, gen_period))
                     : 2 * gen_period + int'($urandom_range(5, 2 * gen_period + 8));
          end else begin
            pad_left = $urandom_range(1, gen_period + 3);
          end
        end
        pad_left--;
        if ($urandom_range(0, 11) == 0) col = 4'($urandom);
        else if (held && !last_drive[2'd3 - pad_row]) col = pad_pattern;
        else col = NO_KEY;
        send_tick(col, 1'b0, IDLE_RES);
      end
      wait_idle();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : result_sink
    int gap;
    mkp_res_t want, got;
    forever begin
      gap = pick_gap(rx_span, rx_eager);
      // one long hold-off so the output backs up and in_tready drops
      if (results_seen == 700) gap = 400;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_seen++;
      got.row_drive  = out_tdata[3:0];
      got.key_valid  = out_tdata[4];
      got.key_code   = out_tdata[12:5];
      got.key_row    = out_tdata[14:13];
      got.key_col    = out_tdata[16:15];
      got.code_done  = out_tdata[17];
      got.code_match = out_tdata[18];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, out_tdata);
      end else begin
        want = expected_q.pop_front();
        check_field("row_drive", want.row_drive, got.row_drive);
        check_field("key_valid", want.key_valid, got.key_valid);
        check_field("key_code", want.key_code, got.key_code);
        check_field("key_row", want.key_row, got.key_row);
        check_field("key_col", want.key_col, got.key_col);
        check_field("code_done", want.code_done, got.code_done);
        check_field("code_match", want.code_match, got.code_match);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- matrix_keypad_scan_password.f -----
+incdir+hw/rtl
hw/rtl/mkp_pkg.sv
hw/rtl/mkp_code_chk.sv
hw/rtl/mkp_scan_core.sv
hw/rtl/matrix_keypad_scan_password.sv
bench/matrix_keypad_scan_password_test.sv
